@@ design/cds_pkg.sv @@
// Shared types, command codes and calendar step functions for the date stepper.
package cds_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0,
    CMD_NEXT = 3'd1,
    CMD_PREV = 3'd2,
    CMD_ADD  = 3'd3,
    CMD_SUB  = 3'd4
  } cmd_e;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 16;

  localparam logic [DayW-1:0]   ResetDay   = 5'd1;
  localparam logic [MonthW-1:0] ResetMonth = 4'd1;
  localparam logic [YearW-1:0]  ResetYear  = 14'd1900;
  localparam logic [YearW-1:0]  YearLast   = 14'd9999;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  // controller -> datapath
  typedef struct packed {
    logic take;     // capture an input beat
    logic step;     // advance one day in the latched direction
    logic publish;  // copy the date into the output register
  } cds_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic slot_free;
  } cds_sts_t;

  function automatic logic is_30_day_month(logic [MonthW-1:0] m);
    return (m == 4'd4) || (m == 4'd6) || (m == 4'd9) || (m == 4'd11);
  endfunction

  // Day is one bit wider so that day+1 and a wrapped day-1 are seen as invalid.
  function automatic logic date_ok(logic [DayW:0] d, logic [MonthW-1:0] m,
                                   logic [YearW-1:0] y);
    logic ok;
    ok = (d >= 6'd1) && (d <= 6'd31) && (m >= 4'd1) && (m <= 4'd12);
    if ((d > 6'd30) && is_30_day_month(m)) ok = 1'b0;
    if ((m == 4'd2) && ((d > 6'd29) || ((d > 6'd28) && (y[1:0] != 2'd0)))) ok = 1'b0;
    return ok;
  endfunction

  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m,
                                                logic [YearW-1:0] y);
    logic [DayW-1:0] len;
    len = 5'd31;
    if (is_30_day_month(m)) len = 5'd30;
    else if (m == 4'd2) len = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
    return len;
  endfunction

  function automatic date_t next_date(date_t cur);
    date_t nd;
    logic [DayW:0] dp1;
    nd  = cur;
    dp1 = {1'b0, cur.day} + 6'd1;
    if (date_ok(dp1, cur.month, cur.year)) begin
      nd.day = dp1[DayW-1:0];
    end else begin
      nd.day   = 5'd1;
      nd.month = cur.month + 4'd1;
      if (!date_ok(6'd1, nd.month, cur.year)) begin
        nd.month = 4'd1;
        nd.year  = (cur.year < YearLast) ? cur.year + 14'd1 : 14'd1;
      end
    end
    return nd;
  endfunction

  function automatic date_t prev_date(date_t cur);
    date_t pd;
    logic [DayW:0] dm1;
    pd  = cur;
    dm1 = {1'b0, cur.day} - 6'd1;
    if (date_ok(dm1, cur.month, cur.year)) begin
      pd.day = dm1[DayW-1:0];
    end else begin
      if ((cur.month >= 4'd2) && (cur.month <= 4'd12)) begin
        pd.month = cur.month - 4'd1;
      end else begin
        pd.month = 4'd12;
        pd.year  = ((cur.year >= 14'd2) && (cur.year <= YearLast)) ?
                   cur.year - 14'd1 : YearLast;
      end
      pd.day = month_len(pd.month, pd.year);
    end
    return pd;
  endfunction

endpackage

@@ design/cds_ctrl.sv @@
// Controller state machine: takes a beat, runs the day steps, hands off the result.
module cds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cds_pkg::cds_sts_t sts_i,
  output cds_pkg::cds_cmd_t cmd_o
);
  import cds_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts_i.cnt_zero) state_d = ST_EMIT;
        else cmd_o.step = 1'b1;
      end
      ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule

@@ design/cds_datapath.sv @@
// Datapath: date registers, step counter, one-day stepper and output register.
module cds_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cds_pkg::cds_cmd_t            cmd_i,
  output cds_pkg::cds_sts_t            sts_o,
  input  logic [2:0]                   command_i,
  input  logic [cds_pkg::DayW-1:0]     load_day_i,
  input  logic [cds_pkg::MonthW-1:0]   load_month_i,
  input  logic [cds_pkg::YearW-1:0]    load_year_i,
  input  logic [cds_pkg::CountW-1:0]   step_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cds_pkg::DayW-1:0]     out_day_o,
  output logic [cds_pkg::MonthW-1:0]   out_month_o,
  output logic [cds_pkg::YearW-1:0]    out_year_o,
  output logic                         date_valid_o
);
  import cds_pkg::*;

  date_t              date_q, date_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               back_q, back_d;
  logic               out_vld_q, out_vld_d;
  date_t              out_date_q;
  logic               out_ok_q;
  cmd_e               cmd;

  assign cmd = cmd_e'(command_i);

  always_comb begin
    date_d = date_q;
    cnt_d  = cnt_q;
    back_d = back_q;
    if (cmd_i.take) begin
      cnt_d = '0;
      case (cmd)
        CMD_LOAD: date_d = '{day: load_day_i, month: load_month_i, year: load_year_i};
        CMD_NEXT: begin cnt_d = CountW'(1); back_d = 1'b0; end
        CMD_PREV: begin cnt_d = CountW'(1); back_d = 1'b1; end
        CMD_ADD:  begin cnt_d = step_count_i; back_d = 1'b0; end
        CMD_SUB:  begin cnt_d = step_count_i; back_d = 1'b1; end
        default:  cnt_d = '0;
      endcase
    end else if (cmd_i.step) begin
      date_d = back_q ? prev_date(date_q) : next_date(date_q);
      cnt_d  = cnt_q - CountW'(1);
    end
  end

  // output register frees up in the same cycle its beat is taken
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.slot_free = !out_vld_q || out_ready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;
    if (cmd_i.publish) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_q    <= '{day: ResetDay, month: ResetMonth, year: ResetYear};
      cnt_q     <= '0;
      back_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      date_q    <= date_d;
      cnt_q     <= cnt_d;
      back_q    <= back_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_date_q <= date_q;
      out_ok_q   <= date_ok({1'b0, date_q.day}, date_q.month, date_q.year);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_day_o    = out_date_q.day;
  assign out_month_o  = out_date_q.month;
  assign out_year_o   = out_date_q.year;
  assign date_valid_o = out_ok_q;

endmodule

@@ design/calendar_date_stepper.sv @@
// Calendar date stepper top level: controller, datapath and checks.
//
// Holds a day/month/year and steps it on command. Input channel
// (in_valid_i/in_ready_o) carries one command beat; output channel
// (out_valid_o/out_ready_i) returns one beat per command: the stored date
// after the command and a flag telling whether that date is legal.
// Load takes the load_* date; unused codes leave the date unchanged;
// next/previous step one day; add/subtract step step_count_i days. The
// day stepper advances one day per cycle. One command is processed at
// a time; in_ready_o is high only while idle.
// The output register is separate from the date state: a waiting result
// does not block the next command from being accepted and stepped, but a
// finished command waits in place until the previous result beat is taken.
// Reset sets the date to 1/1/1900, clears the step counter and empties the
// output register.
module calendar_date_stepper (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  command_i,
  input  logic [cds_pkg::DayW-1:0]    load_day_i,
  input  logic [cds_pkg::MonthW-1:0]  load_month_i,
  input  logic [cds_pkg::YearW-1:0]   load_year_i,
  input  logic [cds_pkg::CountW-1:0]  step_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cds_pkg::DayW-1:0]    out_day_o,
  output logic [cds_pkg::MonthW-1:0]  out_month_o,
  output logic [cds_pkg::YearW-1:0]   out_year_o,
  output logic                        date_valid_o
);
  import cds_pkg::*;

  cds_cmd_t cmd;
  cds_sts_t sts;

  cds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cds_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .command_i    (command_i),
    .load_day_i   (load_day_i),
    .load_month_i (load_month_i),
    .load_year_i  (load_year_i),
    .step_count_i (step_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_day_o    (out_day_o),
    .out_month_o  (out_month_o),
    .out_year_o   (out_year_o),
    .date_valid_o (date_valid_o)
  );

  // after a beat is taken the block is busy
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("in_ready_o high right after accepting a beat");

  // idle means no steps left over
  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> sts.cnt_zero)
    else $error("idle with pending day steps");

  // a new result lands only as the controller returns to idle
  a_publish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |=> (in_ready_o && out_valid_o))
    else $error("publish did not return to idle with a result");

  // steps happen only while busy
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> (!in_ready_o && !sts.cnt_zero))
    else $error("day step outside a running command");

endmodule
